### rtl/qrmcic_pkg.sv
`timescale 1ns / 1ps
package qrmcic_pkg;

  localparam int unsigned ADC_W   = 12;
  localparam int unsigned RATIO_W = 13;
  localparam int unsigned DATA_W  = 64;

  localparam logic [ADC_W-1:0]   ADC_OFFSET  = 12'd2048;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 13'd8000;

  // register indexes (byte address / 4)
  localparam logic REG_DECIM_RATIO = 1'b0;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t i;
    word_t q;
  } iq_t;

  // token moving down the integrator chain; dump marks a sample that ends a block
  typedef struct packed {
    logic dump;
    iq_t  iq;
  } int_tok_t;

endpackage

### rtl/quarter_rate_mixer_cic_decimator_core.sv
`timescale 1ns / 1ps
// fs/4 mixer and CIC decimator. One 12-bit offset-binary sample is taken per clock
// on the slave stream unless stalled; the offset is removed, the sample is routed
// into I or Q with the rotating fs/4 sign, and runs through STAGES integrator
// cells and, for every decimation_ratio-th sample, STAGES comb cells. Each cell is
// one 64-bit add or subtract per channel, so a new sample is accepted every cycle
// unless the master side holds off; a result is registered in each integrator and
// comb cell. Cells only stall when the master side holds off, and tokens close up
// behind the stall. decimation_ratio (APB address 0, reset 8000) counts samples
// per result; zero acts as one. Write it only while the block is idle.
module quarter_rate_mixer_cic_decimator_core #(
  parameter int unsigned STAGES = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [15:0]  s_axis_tdata_i,   // [11:0] adc_sample
  // master stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o,   // [63:0] i_out, [127:64] q_out
  // APB
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import qrmcic_pkg::*;

  localparam logic [1:0] PH_SUB_I = 2'd0;
  localparam logic [1:0] PH_SUB_Q = 2'd1;
  localparam logic [1:0] PH_ADD_I = 2'd2;
  localparam logic [1:0] PH_ADD_Q = 2'd3;

  // ---------------- configuration
  logic [RATIO_W-1:0] ratio_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RATIO_RESET;
    end else if (cfg_wr && (paddr[2] == REG_DECIM_RATIO)) begin
      ratio_q <= pwdata[RATIO_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DECIM_RATIO) begin
      prdata = {{(32-RATIO_W){1'b0}}, ratio_q};
    end
  end

  // ---------------- mixer and decimation counter
  logic [1:0]         phase_q;
  logic [RATIO_W-1:0] count_q;
  logic               s_fire;
  logic               emit;
  logic [RATIO_W:0]   count_inc;
  logic signed [ADC_W:0] smp;
  word_t              smp_ext;
  word_t              smp_neg;
  int_tok_t           in_tok;

  assign s_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign count_inc = {1'b0, count_q} + {{RATIO_W{1'b0}}, 1'b1};
  assign emit      = count_inc >= {1'b0, ratio_q};

  assign smp     = $signed({1'b0, s_axis_tdata_i[ADC_W-1:0]}) - $signed({1'b0, ADC_OFFSET});
  assign smp_ext = {{(DATA_W-ADC_W-1){smp[ADC_W]}}, smp};
  assign smp_neg = '0 - smp_ext;

  always_comb begin
    in_tok.dump = emit;
    in_tok.iq.i = '0;
    in_tok.iq.q = '0;
    case (phase_q)
      PH_SUB_I: in_tok.iq.i = smp_neg;
      PH_SUB_Q: in_tok.iq.q = smp_neg;
      PH_ADD_I: in_tok.iq.i = smp_ext;
      PH_ADD_Q: in_tok.iq.q = smp_ext;
      default:  in_tok.iq.i = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SUB_I;
      count_q <= '0;
    end else if (s_fire) begin
      phase_q <= phase_q + 2'd1;
      count_q <= emit ? '0 : count_inc[RATIO_W-1:0];
    end
  end

  // ---------------- integrator chain
  logic     int_valid [STAGES+1];
  logic     int_ready [STAGES+1];
  int_tok_t int_tok   [STAGES+1];

  logic     cmb_valid [STAGES+1];
  logic     cmb_ready [STAGES+1];
  iq_t      cmb_iq    [STAGES+1];

  assign int_valid[0]    = s_axis_tvalid_i;
  assign int_tok[0]      = in_tok;
  assign s_axis_tready_o = int_ready[0];

  for (genvar k = 0; k < STAGES; k++) begin : g_integ
    qrmcic_integ_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (int_valid[k]),
      .in_ready_o (int_ready[k]),
      .in_tok_i   (int_tok[k]),
      .out_valid_o(int_valid[k+1]),
      .out_ready_i(int_ready[k+1]),
      .out_tok_o  (int_tok[k+1])
    );
  end

  // samples that do not end a block are dropped after the last integrator
  assign int_ready[STAGES] = !int_tok[STAGES].dump || cmb_ready[0];
  assign cmb_valid[0]      = int_valid[STAGES] && int_tok[STAGES].dump;
  assign cmb_iq[0]         = int_tok[STAGES].iq;

  // ---------------- comb chain
  for (genvar k = 0; k < STAGES; k++) begin : g_comb
    qrmcic_comb_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (cmb_valid[k]),
      .in_ready_o (cmb_ready[k]),
      .in_iq_i    (cmb_iq[k]),
      .out_valid_o(cmb_valid[k+1]),
      .out_ready_i(cmb_ready[k+1]),
      .out_iq_o   (cmb_iq[k+1])
    );
  end

  assign cmb_ready[STAGES] = m_axis_tready_i;
  assign m_axis_tvalid_o   = cmb_valid[STAGES];
  assign m_axis_tdata_o    = {cmb_iq[STAGES].q, cmb_iq[STAGES].i};

  // ---------------- assertions
  a_phase_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> phase_q == $past(phase_q) + 2'd1)
    else $error("mixer phase did not advance by one");

  a_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && emit |=> count_q == '0)
    else $error("decimation count not cleared after block end");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  a_hold_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_fire |=> $stable(count_q) && $stable(phase_q))
    else $error("mixer state moved without an accepted request");

endmodule

### rtl/qrmcic_integ_cell.sv
`timescale 1ns / 1ps
module qrmcic_integ_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  qrmcic_pkg::int_tok_t in_tok_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qrmcic_pkg::int_tok_t out_tok_o
);
  import qrmcic_pkg::*;

  logic  valid_q;
  logic  dump_q;
  word_t acc_i_q, acc_q_q;
  logic  load;

  // the cell takes a request when empty or when its own token moves on
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      acc_i_q <= '0;
      acc_q_q <= '0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
      if (in_valid_i) begin
        acc_i_q <= acc_i_q + in_tok_i.iq.i;
        acc_q_q <= acc_q_q + in_tok_i.iq.q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dump_q <= in_tok_i.dump;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_tok_o.dump = dump_q;
  assign out_tok_o.iq.i = acc_i_q;
  assign out_tok_o.iq.q = acc_q_q;

endmodule

### rtl/qrmcic_comb_cell.sv
`timescale 1ns / 1ps
module qrmcic_comb_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  qrmcic_pkg::iq_t in_iq_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output qrmcic_pkg::iq_t out_iq_o
);
  import qrmcic_pkg::*;

  logic valid_q;
  iq_t  dly_q;
  iq_t  y_q;
  logic load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dly_q   <= '0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (load) begin
        dly_q <= in_iq_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      y_q.i <= in_iq_i.i - dly_q.i;
      y_q.q <= in_iq_i.q - dly_q.q;
    end
  end

  assign out_valid_o = valid_q;
  assign out_iq_o    = y_q;

endmodule

### verif/quarter_rate_mixer_cic_decimator_core_tb.sv
`timescale 1ns / 1ps
module quarter_rate_mixer_cic_decimator_core_tb;
  import qrmcic_pkg::*;

  localparam int STG       = 4;
  localparam int DRAIN     = 2 * STG + 8;
  localparam int LONG_HOLD = 200;
  localparam int RAMP_LEN  = 72;
  localparam int DIR_ROWS  = 20;
  localparam longint LIMIT_NS = 64'd5_000_000;
  localparam logic [2:0] RATIO_ADDR = {REG_DECIM_RATIO, 2'b00};

  typedef enum logic [1:0] {PH_I_SUB, PH_Q_SUB, PH_I_ADD, PH_Q_ADD} mix_phase_e;
  typedef enum logic {ROW_RATIO, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [12:0] val;
    logic        typed;
    iq_t         exp;
  } dir_row_t;

  typedef struct packed {
    logic typed;
    iq_t  exp;
  } sample_note_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [15:0]  s_axis_tdata_i;   // [11:0] adc_sample
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [127:0] m_axis_tdata_o;   // [63:0] i_out, [127:64] q_out
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  quarter_rate_mixer_cic_decimator_core #(.STAGES(STG)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // predictor state
  logic [12:0] ratio_cfg;
  mix_phase_e  mix_ph;
  logic [12:0] decim_cnt;
  word_t       integ_i [STG];
  word_t       integ_q [STG];
  word_t       comb_i [STG];
  word_t       comb_q [STG];

  iq_t          iq_expect_q [$];
  sample_note_t sample_note_q [$];

  int err_cnt;
  int n_items;
  int n_results;
  int n_settings;
  int fed_cnt;
  bit quiet;
  bit hold_long;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_NS);
    $display("quarter_rate_mixer_cic_decimator_core_tb: done, errors");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= 30) $display("MISMATCH: %s", what);
  endtask

  task automatic cic_step(input logic [11:0] smp, output logic fire, output iq_t res);
    word_t s;
    word_t xi;
    word_t xq;
    word_t yi;
    word_t yq;
    s = word_t'(smp) - word_t'(ADC_OFFSET);
    case (mix_ph)
      PH_I_SUB: integ_i[0] = integ_i[0] - s;
      PH_Q_SUB: integ_q[0] = integ_q[0] - s;
      PH_I_ADD: integ_i[0] = integ_i[0] + s;
      default:  integ_q[0] = integ_q[0] + s;
    endcase
    mix_ph = mix_ph.next();
    for (int st = 1; st < STG; st++) begin
      integ_i[st] = integ_i[st] + integ_i[st-1];
      integ_q[st] = integ_q[st] + integ_q[st-1];
    end
    fire = 1'b0;
    res  = '0;
    // ratio zero behaves as one; a count above a lowered ratio fires at once
    if (32'(decim_cnt) + 1 < 32'(ratio_cfg)) begin
      decim_cnt = decim_cnt + 13'd1;
    end else begin
      decim_cnt = '0;
      xi = integ_i[STG-1];
      xq = integ_q[STG-1];
      for (int st = 0; st < STG; st++) begin
        yi = xi - comb_i[st];
        yq = xq - comb_q[st];
        comb_i[st] = xi;
        comb_q[st] = xq;
        xi = yi;
        xq = yq;
      end
      fire = 1'b1;
      res.i = xi;
      res.q = xq;
    end
  endtask

  task automatic take_sample(input logic [11:0] smp);
    sample_note_t note;
    logic         fire;
    iq_t          res;
    note = sample_note_q.pop_front();
    cic_step(smp, fire, res);
    if (fire) iq_expect_q.push_back(note.typed ? note.exp : res);
  endtask

  task automatic check_result(input logic [127:0] d);
    iq_t want;
    if (iq_expect_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected result i=%h q=%h", d[63:0], d[127:64]));
    end else begin
      want = iq_expect_q.pop_front();
      n_results++;
      if (d[63:0] !== want.i)
        flag_mismatch($sformatf("result %0d i_out %h, want %h", n_results, d[63:0], want.i));
      if (d[127:64] !== want.q)
        flag_mismatch($sformatf("result %0d q_out %h, want %h", n_results, d[127:64], want.q));
    end
  endtask

  // output checked before the input is folded in, all from one process
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) check_result(m_axis_tdata_o);
      if (s_axis_tvalid_i && s_axis_tready_o) take_sample(s_axis_tdata_i[11:0]);
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        m_axis_tready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  task automatic apb_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= RATIO_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // block idle: nothing pending and the pipeline drained
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (iq_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic program_ratio(input logic [12:0] r);
    logic [31:0] rd;
    settle();
    apb_xfer(1'b1, {19'd0, r}, rd);
    ratio_cfg = r;
    n_settings++;
    apb_xfer(1'b0, '0, rd);
    if (rd !== {19'd0, r}) flag_mismatch($sformatf("ratio readback %0d, want %0d", rd, r));
  endtask

  task automatic push_sample(input logic [11:0] smp, input logic typed, input iq_t exp);
    sample_note_t note;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    note.typed = typed;
    note.exp   = exp;
    sample_note_q.push_back(note);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'd0, smp};
    do @(posedge clk_i); while (!s_axis_tready_o);
    fed_cnt++;
    n_items++;
  endtask

  function automatic logic [11:0] pick_sample(input mix_phase_e ph);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 12'($urandom_range(0, 4095));
      5, 6: begin
        case ($urandom_range(0, 3))
          0:       return 12'd0;
          1:       return 12'd4095;
          2:       return 12'd2047;
          default: return 12'd2048;
        endcase
      end
      // follow the mixer so the integrators keep climbing
      default: begin
        if (ph == PH_I_SUB || ph == PH_Q_SUB) return 12'($urandom_range(0, 255));
        return 12'($urandom_range(3840, 4095));
      end
    endcase
  endfunction

  dir_row_t dir_tab [DIR_ROWS];

  initial begin
    logic [31:0] rd;
    logic [12:0] r;
    logic [11:0] smp;
    int          n;
    mix_phase_e  ph;

    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    err_cnt    = 0;
    n_items    = 0;
    n_results  = 0;
    n_settings = 0;
    fed_cnt    = 0;
    quiet      = 1'b0;
    hold_long  = 1'b0;
    ratio_cfg  = RATIO_RESET;
    mix_ph     = PH_I_SUB;
    decim_cnt  = '0;
    for (int st = 0; st < STG; st++) begin
      integ_i[st] = '0;
      integ_q[st] = '0;
      comb_i[st]  = '0;
      comb_q[st]  = '0;
    end

    dir_tab[0]  = '{ROW_RATIO,  13'd1,    1'b0, '0};
    dir_tab[1]  = '{ROW_SAMPLE, 13'd0,    1'b1, '{64'd2048, 64'd0}};
    dir_tab[2]  = '{ROW_SAMPLE, 13'd4095, 1'b1, '{64'd0, -64'sd2047}};
    dir_tab[3]  = '{ROW_SAMPLE, 13'd2048, 1'b0, '0};
    dir_tab[4]  = '{ROW_SAMPLE, 13'd2047, 1'b0, '0};
    dir_tab[5]  = '{ROW_SAMPLE, 13'd2049, 1'b0, '0};
    dir_tab[6]  = '{ROW_SAMPLE, 13'd1,    1'b0, '0};
    dir_tab[7]  = '{ROW_SAMPLE, 13'd4094, 1'b0, '0};
    dir_tab[8]  = '{ROW_RATIO,  13'd0,    1'b0, '0};   // zero acts as one
    dir_tab[9]  = '{ROW_SAMPLE, 13'h555,  1'b0, '0};
    dir_tab[10] = '{ROW_SAMPLE, 13'hAAA,  1'b0, '0};
    dir_tab[11] = '{ROW_RATIO,  13'd5,    1'b0, '0};
    dir_tab[12] = '{ROW_SAMPLE, 13'd2048, 1'b0, '0};
    dir_tab[13] = '{ROW_SAMPLE, 13'd4095, 1'b0, '0};
    dir_tab[14] = '{ROW_SAMPLE, 13'd0,    1'b0, '0};
    dir_tab[15] = '{ROW_RATIO,  13'd2,    1'b0, '0};   // now below the count
    dir_tab[16] = '{ROW_SAMPLE, 13'd0,    1'b0, '0};
    dir_tab[17] = '{ROW_SAMPLE, 13'd4095, 1'b0, '0};
    dir_tab[18] = '{ROW_SAMPLE, 13'd4095, 1'b0, '0};
    dir_tab[19] = '{ROW_SAMPLE, 13'd0,    1'b0, '0};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_xfer(1'b0, '0, rd);
    if (rd !== {19'd0, RATIO_RESET})
      flag_mismatch($sformatf("ratio after reset %0d, want %0d", rd, RATIO_RESET));

    for (int k = 0; k < DIR_ROWS; k++) begin
      if (dir_tab[k].kind == ROW_RATIO) program_ratio(dir_tab[k].val);
      else push_sample(dir_tab[k].val[11:0], dir_tab[k].typed, dir_tab[k].exp);
    end

    // output held off long enough that the pipeline backs up into the input
    program_ratio(13'd1);
    hold_long = 1'b1;
    for (int k = 0; k < 60; k++) begin
      ph = mix_phase_e'(fed_cnt[1:0]);
      push_sample(pick_sample(ph), 1'b0, '0);
    end

    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 5))
        0:       r = 13'($urandom_range(0, 1));
        1:       r = 13'($urandom_range(2, 4));
        2:       r = 13'($urandom_range(5, 12));
        3:       r = 13'($urandom_range(13, 40));
        4:       r = 13'd1;
        default: r = 13'd8;
      endcase
      program_ratio(r);
      quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(35, 95);
      for (int k = 0; k < n; k++) begin
        if (p == 2 && k == n / 2) begin
          s_axis_tvalid_i <= 1'b0;
          do @(posedge clk_i); while (iq_expect_q.size() != 0);
        end
        ph = mix_phase_e'(fed_cnt[1:0]);
        push_sample(pick_sample(ph), 1'b0, '0);
      end
    end

    // largest ratio, then lowered under the running count: next sample emits at once
    quiet = 1'b1;
    program_ratio(13'd8191);
    for (int k = 0; k < 24; k++) push_sample(12'($urandom_range(0, 4095)), 1'b0, '0);
    program_ratio(13'd3);

    // full-scale samples aligned to the mixer, no idling on either side
    for (int k = 0; k < RAMP_LEN; k++) begin
      ph = mix_phase_e'(fed_cnt[1:0]);
      if ($urandom_range(0, 7) == 0) smp = 12'($urandom_range(0, 4095));
      else if (ph == PH_I_SUB || ph == PH_Q_SUB) smp = 12'd0;
      else smp = 12'd4095;
      push_sample(smp, 1'b0, '0);
    end

    s_axis_tvalid_i <= 1'b0;
    while (iq_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("coverage: %0d samples in, %0d results checked, %0d ratio writes (0 to 8191)",
             n_items, n_results, n_settings);
    $display("coverage: output back-pressure stall, idle pause, ratio cut under the count");
    if (err_cnt == 0) begin
      $display("quarter_rate_mixer_cic_decimator_core_tb: done, clean");
    end else begin
      $display("quarter_rate_mixer_cic_decimator_core_tb: done, errors");
    end
    $finish;
  end

endmodule
